@@ sv/lcdnf_pkg.sv @@
// lcdnf_pkg: shared types, step codes and the control store of the lcd number formatter
// depends on nothing; used by lcdnf_seq, lcdnf_dp and the top level
`timescale 1ns / 1ps

package lcdnf_pkg;

  localparam int MaxDigits = 16;
  localparam int CntW      = $clog2(MaxDigits + 1);

  // request modes
  localparam logic [2:0] ModeChar = 3'd0;
  localparam logic [2:0] ModeUdec = 3'd1;
  localparam logic [2:0] ModeSdec = 3'd2;
  localparam logic [2:0] ModeHex  = 3'd3;
  localparam logic [2:0] ModeBin  = 3'd4;

  // bus constants
  localparam logic [7:0] CmdSetAddr  = 8'h80;
  localparam logic [7:0] Line2Offset = 8'h40;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChMinus     = 8'h2D;

  typedef logic [3:0] step_t;

  localparam step_t StIdle    = 4'd0;
  localparam step_t StLine    = 4'd1;
  localparam step_t StCmd     = 4'd2;
  localparam step_t StModeChk = 4'd3;
  localparam step_t StChar    = 4'd4;
  localparam step_t StDecChk  = 4'd5;
  localparam step_t StDabble  = 4'd6;
  localparam step_t StSignChk = 4'd7;
  localparam step_t StSign    = 4'd8;
  localparam step_t StDigChk  = 4'd9;
  localparam step_t StDigit   = 4'd10;
  localparam step_t StFlush   = 4'd11;

  typedef enum logic [2:0] {
    EMIT_NONE, EMIT_CMD, EMIT_CHAR, EMIT_SIGN, EMIT_DIGIT
  } emit_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_DABBLE, OP_NEXT_DIGIT, OP_FLUSH
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NOT_START, C_LINE_NONE, C_NOT_CHAR, C_NOT_DEC,
    C_BITS_MORE, C_NOT_SIGNED, C_NO_DIGITS, C_DIGITS_MORE
  } cond_t;

  typedef struct packed {
    emit_t emit;
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic line_none;
    logic not_char;
    logic not_dec;
    logic bits_more;
    logic not_signed;
    logic no_digits;
    logic digits_more;
  } flags_t;

  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t uc;
    unique case (pc)
      StIdle:    uc = '{EMIT_NONE,  OP_LOAD,       C_NOT_START,   StIdle};
      StLine:    uc = '{EMIT_NONE,  OP_NONE,       C_LINE_NONE,   StModeChk};
      StCmd:     uc = '{EMIT_CMD,   OP_NONE,       C_NEVER,       StIdle};
      StModeChk: uc = '{EMIT_NONE,  OP_NONE,       C_NOT_CHAR,    StDecChk};
      StChar:    uc = '{EMIT_CHAR,  OP_NONE,       C_ALWAYS,      StFlush};
      StDecChk:  uc = '{EMIT_NONE,  OP_NONE,       C_NOT_DEC,     StDigChk};
      StDabble:  uc = '{EMIT_NONE,  OP_DABBLE,     C_BITS_MORE,   StDabble};
      StSignChk: uc = '{EMIT_NONE,  OP_NONE,       C_NOT_SIGNED,  StDigChk};
      StSign:    uc = '{EMIT_SIGN,  OP_NONE,       C_NEVER,       StIdle};
      StDigChk:  uc = '{EMIT_NONE,  OP_NONE,       C_NO_DIGITS,   StFlush};
      StDigit:   uc = '{EMIT_DIGIT, OP_NEXT_DIGIT, C_DIGITS_MORE, StDigit};
      StFlush:   uc = '{EMIT_NONE,  OP_FLUSH,      C_ALWAYS,      StIdle};
      default:   uc = '{EMIT_NONE,  OP_NONE,       C_ALWAYS,      StIdle};
    endcase
    return uc;
  endfunction

endpackage

@@ sv/lcdnf_seq.sv @@
// lcdnf_seq: step counter, control store lookup and jump condition select
// depends on lcdnf_pkg
`timescale 1ns / 1ps

module lcdnf_seq (
  input  logic              clk,
  input  logic              rst,
  input  lcdnf_pkg::flags_t flags,
  output lcdnf_pkg::ucode_t uc,
  output logic              busy
);

  lcdnf_pkg::step_t pc;
  lcdnf_pkg::step_t pc_next;
  logic             take;

  assign uc   = lcdnf_pkg::ucode_rom(pc);
  assign busy = (pc != lcdnf_pkg::StIdle);

  always_comb begin
    unique case (uc.cond)
      lcdnf_pkg::C_NEVER:       take = 1'b0;
      lcdnf_pkg::C_ALWAYS:      take = 1'b1;
      lcdnf_pkg::C_NOT_START:   take = !flags.start;
      lcdnf_pkg::C_LINE_NONE:   take = flags.line_none;
      lcdnf_pkg::C_NOT_CHAR:    take = flags.not_char;
      lcdnf_pkg::C_NOT_DEC:     take = flags.not_dec;
      lcdnf_pkg::C_BITS_MORE:   take = flags.bits_more;
      lcdnf_pkg::C_NOT_SIGNED:  take = flags.not_signed;
      lcdnf_pkg::C_NO_DIGITS:   take = flags.no_digits;
      lcdnf_pkg::C_DIGITS_MORE: take = flags.digits_more;
      default:                  take = 1'b1;
    endcase
    pc_next = take ? uc.target : pc + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lcdnf_pkg::StIdle;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ sv/lcdnf_dp.sv @@
// lcdnf_dp: request registers, double-dabble converter, digit select and write buffer
// depends on lcdnf_pkg; driven by the control word from lcdnf_seq
`timescale 1ns / 1ps

module lcdnf_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        mode,
  input  logic [1:0]        line,
  input  logic [4:0]        column,
  input  logic [15:0]       number,
  input  logic [4:0]        digit_count,
  input  logic [7:0]        character,
  input  lcdnf_pkg::ucode_t uc,
  output lcdnf_pkg::flags_t flags,
  output logic              strobe,
  output logic              is_data,
  output logic [7:0]        bus_byte,
  output logic              last
);

  logic [2:0]                mode_r;
  logic [1:0]                line_r;
  logic [4:0]                column_r;
  logic [7:0]                char_r;
  logic [15:0]               value;
  logic                      neg;
  logic [lcdnf_pkg::CntW-1:0] cnt;
  logic [3:0]                bitcnt;
  logic [19:0]               bcd;

  logic       pend_valid;
  logic       pend_is_data;
  logic [7:0] pend_byte;

  logic [19:0]               bcd_adj;
  logic [lcdnf_pkg::CntW-1:0] cnt_m1;
  logic [3:0]                pos;
  logic [3:0]                dig;
  logic [7:0]                dig_char;
  logic [7:0]                addr;
  logic [7:0]                new_byte;
  logic                      new_is_data;
  logic                      emitting;

  assign flags.start       = start;
  assign flags.line_none   = (line_r != 2'd1) && (line_r != 2'd2);
  assign flags.not_char    = (mode_r != lcdnf_pkg::ModeChar);
  assign flags.not_dec     = (mode_r != lcdnf_pkg::ModeUdec) && (mode_r != lcdnf_pkg::ModeSdec);
  assign flags.bits_more   = (bitcnt != 4'd0);
  assign flags.not_signed  = (mode_r != lcdnf_pkg::ModeSdec);
  assign flags.no_digits   = (cnt == '0) || (mode_r > lcdnf_pkg::ModeBin);
  assign flags.digits_more = (cnt != lcdnf_pkg::CntW'(1));

  // add 3 to each bcd digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      bcd_adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
  end

  assign cnt_m1 = cnt - lcdnf_pkg::CntW'(1);
  assign pos    = cnt_m1[3:0];

  always_comb begin
    dig = 4'd0;
    priority if (mode_r == lcdnf_pkg::ModeHex) begin
      if (pos < 4'd4) dig = value[{pos[1:0], 2'b00} +: 4];
    end else if (mode_r == lcdnf_pkg::ModeBin) begin
      dig = {3'b000, value[pos]};
    end else begin
      unique case (pos)
        4'd0:    dig = bcd[3:0];
        4'd1:    dig = bcd[7:4];
        4'd2:    dig = bcd[11:8];
        4'd3:    dig = bcd[15:12];
        4'd4:    dig = bcd[19:16];
        default: dig = 4'd0;
      endcase
    end
    dig_char = (dig < 4'd10) ? lcdnf_pkg::ChZero + {4'd0, dig}
                             : lcdnf_pkg::ChUpperA + {4'd0, dig} - 8'd10;
  end

  // column is one-based, so column 0 wraps round
  assign addr = {3'b000, column_r} + 8'hFF + ((line_r == 2'd2) ? lcdnf_pkg::Line2Offset : 8'h00);

  always_comb begin
    emitting    = 1'b1;
    new_is_data = 1'b1;
    new_byte    = dig_char;
    unique case (uc.emit)
      lcdnf_pkg::EMIT_NONE:  emitting = 1'b0;
      lcdnf_pkg::EMIT_CMD: begin
        new_is_data = 1'b0;
        new_byte    = lcdnf_pkg::CmdSetAddr | addr;
      end
      lcdnf_pkg::EMIT_CHAR:  new_byte = char_r;
      lcdnf_pkg::EMIT_SIGN:  new_byte = neg ? lcdnf_pkg::ChMinus : lcdnf_pkg::ChPlus;
      lcdnf_pkg::EMIT_DIGIT: new_byte = dig_char;
      default:               emitting = 1'b0;
    endcase
  end

  // request and converter registers
  always_ff @(posedge clk) begin
    unique case (uc.op)
      lcdnf_pkg::OP_LOAD: begin
        mode_r   <= mode;
        line_r   <= line;
        column_r <= column;
        char_r   <= character;
        neg      <= number[15];
        value    <= (mode == lcdnf_pkg::ModeSdec && number[15]) ? 16'd0 - number : number;
        cnt      <= (digit_count > lcdnf_pkg::CntW'(lcdnf_pkg::MaxDigits))
                    ? lcdnf_pkg::CntW'(lcdnf_pkg::MaxDigits) : digit_count[lcdnf_pkg::CntW-1:0];
        bitcnt   <= 4'd15;
        bcd      <= '0;
      end
      lcdnf_pkg::OP_DABBLE: begin
        bcd    <= {bcd_adj[18:0], value[15]};
        value  <= {value[14:0], 1'b0};
        bitcnt <= bitcnt - 4'd1;
      end
      lcdnf_pkg::OP_NEXT_DIGIT: cnt <= cnt_m1;
      default: ;
    endcase
  end

  // one write is held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (emitting) begin
        strobe       <= pend_valid;
        is_data      <= pend_is_data;
        bus_byte     <= pend_byte;
        last         <= 1'b0;
        pend_valid   <= 1'b1;
        pend_is_data <= new_is_data;
        pend_byte    <= new_byte;
      end else if (uc.op == lcdnf_pkg::OP_FLUSH) begin
        strobe     <= pend_valid;
        is_data    <= pend_is_data;
        bus_byte   <= pend_byte;
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/char_lcd_number_formatter_top.sv @@
// char_lcd_number_formatter_top: microcoded number formatter for a 2-line character lcd
// depends on lcdnf_pkg, lcdnf_seq and lcdnf_dp
//
//   channel  | direction | handshake       | payload
//   request  | in        | start / busy    | mode line column number digit_count character
//   write    | out       | strobe          | is_data bus_byte last
//
// a request is taken when start is high and busy low; busy then stays high until the
// final write has been placed on the outputs (cycle of that write has busy low)
// decimal requests run the 16-step double-dabble loop before their digits (signed
// decimal adds a sign step), and every digit in each numeric mode has one control step
// synchronous reset returns the step counter to idle and drops any held write
// each write shows for one cycle with strobe high; the receiver cannot stall
`timescale 1ns / 1ps

module char_lcd_number_formatter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [1:0]  line,
  input  logic [4:0]  column,
  input  logic [15:0] number,
  input  logic [4:0]  digit_count,
  input  logic [7:0]  character,
  output logic        strobe,
  output logic        is_data,
  output logic [7:0]  bus_byte,
  output logic        last
);

  lcdnf_pkg::ucode_t uc;
  lcdnf_pkg::flags_t flags;

  lcdnf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uc    (uc),
    .busy  (busy)
  );

  lcdnf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .line        (line),
    .column      (column),
    .number      (number),
    .digit_count (digit_count),
    .character   (character),
    .uc          (uc),
    .flags       (flags),
    .strobe      (strobe),
    .is_data     (is_data),
    .bus_byte    (bus_byte),
    .last        (last)
  );

  // the final write of a request lands as the sequencer returns to idle
  a_last_at_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("final write seen while sequencer still busy");

  a_mid_write_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("non-final write seen with sequencer idle");

  a_transfer_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer did not start the sequencer");

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for char_lcd_number_formatter_top
// depends on lcdnf_pkg and the formatter rtl; a built-in predictor checks every bus write
`timescale 1ns / 1ps

module tb_top;

  localparam int          CycleLimit  = 300000;
  localparam int          DrainCycles = 64;
  localparam int          RandomReqs  = 320;
  localparam logic [2:0]  ModeSpareLo = 3'd5;
  localparam logic [2:0]  ModeSpareHi = 3'd7;

  typedef struct {
    logic [2:0]  mode;
    logic [1:0]  line;
    logic [4:0]  column;
    logic [15:0] number;
    logic [4:0]  digit_count;
    logic [7:0]  character;
  } lcd_req_t;

  typedef struct {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = '0;
  logic [1:0]  line = '0;
  logic [4:0]  column = '0;
  logic [15:0] number = '0;
  logic [4:0]  digit_count = '0;
  logic [7:0]  character = '0;
  logic        strobe;
  logic        is_data;
  logic [7:0]  bus_byte;
  logic        last;

  lcd_req_t   pending_reqs[$];
  lcd_write_t expected_writes[$];
  lcd_write_t exp_w;
  int         gap_left = 0;
  int         burst_left = 0;
  int         cycle_count = 0;
  bit         failed = 1'b0;

  char_lcd_number_formatter_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .line(line), .column(column), .number(number),
    .digit_count(digit_count), .character(character),
    .strobe(strobe), .is_data(is_data), .bus_byte(bus_byte), .last(last)
  );

  always #1 clk = ~clk;

  function automatic void push_write(input logic data_flag, input logic [7:0] b);
    lcd_write_t w;
    w.is_data  = data_flag;
    w.bus_byte = b;
    w.last     = 1'b0;
    expected_writes.push_back(w);
  endfunction

  // works out the bus writes that one request causes
  function automatic void format_writes(input lcd_req_t req);
    int unsigned     n;
    int unsigned     radix;
    int unsigned     d;
    int unsigned     pos;
    int              base_size;
    logic [31:0]     value;
    longint unsigned scale;
    logic [7:0]      offset;
    base_size = expected_writes.size();
    n = (req.digit_count > lcdnf_pkg::MaxDigits) ? lcdnf_pkg::MaxDigits : req.digit_count;
    value = {16'h0000, req.number};
    radix = 0;
    if (req.line == 2'd1 || req.line == 2'd2) begin
      offset = (req.line == 2'd2) ? lcdnf_pkg::Line2Offset : 8'h00;
      // column 0 wraps round, as column minus one is taken in eight bits
      push_write(1'b0, lcdnf_pkg::CmdSetAddr | (8'(req.column) - 8'd1 + offset));
    end
    case (req.mode)
      lcdnf_pkg::ModeChar: push_write(1'b1, req.character);
      lcdnf_pkg::ModeUdec: radix = 10;
      lcdnf_pkg::ModeSdec: begin
        radix = 10;
        if (req.number[15]) begin
          push_write(1'b1, lcdnf_pkg::ChMinus);
          value = (32'h10000 - value) & 32'h1FFFF;
        end else begin
          push_write(1'b1, lcdnf_pkg::ChPlus);
        end
      end
      lcdnf_pkg::ModeHex:  radix = 16;
      lcdnf_pkg::ModeBin:  radix = 2;
      default:  radix = 0;
    endcase
    if (radix != 0) begin
      for (int i = n; i > 0; i--) begin
        pos = i - 1;
        if (radix == 10) begin
          scale = 1;
          repeat (pos) scale = scale * 10;
          d = int'((longint'(value) / scale) % 10);
        end else if (radix == 16) begin
          d = (value >> (4 * pos)) & 32'hF;
        end else begin
          d = (value >> pos) & 32'h1;
        end
        push_write(1'b1, (d < 10) ? lcdnf_pkg::ChZero + 8'(d)
                                  : lcdnf_pkg::ChUpperA + 8'(d - 10));
      end
    end
    if (expected_writes.size() > base_size)
      expected_writes[expected_writes.size() - 1].last = 1'b1;
  endfunction

  // mostly short gaps, a few long ones, and now and then a burst with none
  function automatic int pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_req(input logic [2:0] m, input logic [1:0] ln, input logic [4:0] col,
                         input logic [15:0] num, input logic [4:0] dc, input logic [7:0] ch);
    lcd_req_t r;
    r.mode        = m;
    r.line        = ln;
    r.column      = col;
    r.number      = num;
    r.digit_count = dc;
    r.character   = ch;
    pending_reqs.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        format_writes(pending_reqs.pop_front());
      end
      if (!start || !busy) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start       <= 1'b0;
          mode        <= 3'($urandom);
          line        <= 2'($urandom);
          column      <= 5'($urandom);
          number      <= 16'($urandom);
          digit_count <= 5'($urandom);
          character   <= 8'($urandom);
        end else begin
          start       <= 1'b1;
          mode        <= pending_reqs[0].mode;
          line        <= pending_reqs[0].line;
          column      <= pending_reqs[0].column;
          number      <= pending_reqs[0].number;
          digit_count <= pending_reqs[0].digit_count;
          character   <= pending_reqs[0].character;
          gap_left = pick_gap();
        end
      end
    end
  end

  // write monitor: every strobed write is a transfer that cannot be held off
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected write: is_data %b bus_byte %h last %b", is_data, bus_byte, last);
        failed = 1'b1;
      end else begin
        exp_w = expected_writes.pop_front();
        if (is_data !== exp_w.is_data) begin
          $error("is_data: expected %b, got %b", exp_w.is_data, is_data);
          failed = 1'b1;
        end
        if (bus_byte !== exp_w.bus_byte) begin
          $error("bus_byte: expected %h, got %h", exp_w.bus_byte, bus_byte);
          failed = 1'b1;
        end
        if (last !== exp_w.last) begin
          $error("last: expected %b, got %b", exp_w.last, last);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    lcd_req_t r;
    // directed part: field extremes, every mode, wrap and saturation corners
    add_req(lcdnf_pkg::ModeChar, 2'd1, 5'd1,  16'h0000, 5'd0,  8'h00);
    add_req(lcdnf_pkg::ModeChar, 2'd2, 5'd16, 16'hFFFF, 5'd31, 8'hFF);
    add_req(lcdnf_pkg::ModeChar, 2'd1, 5'd0,  16'h1234, 5'd3,  8'h41);
    add_req(lcdnf_pkg::ModeChar, 2'd2, 5'd0,  16'h0000, 5'd0,  8'h5A);
    add_req(lcdnf_pkg::ModeChar, 2'd0, 5'd31, 16'h0000, 5'd0,  8'hA5);
    add_req(lcdnf_pkg::ModeChar, 2'd3, 5'd31, 16'h0000, 5'd0,  8'h7E);
    add_req(lcdnf_pkg::ModeUdec, 2'd1, 5'd16, 16'hFFFF, 5'd16, 8'h00);
    add_req(lcdnf_pkg::ModeUdec, 2'd2, 5'd1,  16'h0000, 5'd5,  8'h00);
    add_req(lcdnf_pkg::ModeUdec, 2'd1, 5'd3,  16'd12345, 5'd0, 8'h00);
    add_req(lcdnf_pkg::ModeUdec, 2'd0, 5'd3,  16'd54321, 5'd31, 8'h00);
    add_req(lcdnf_pkg::ModeSdec, 2'd1, 5'd1,  16'h8000, 5'd5,  8'h00);
    add_req(lcdnf_pkg::ModeSdec, 2'd2, 5'd8,  16'h7FFF, 5'd5,  8'h00);
    add_req(lcdnf_pkg::ModeSdec, 2'd1, 5'd2,  16'hFFFF, 5'd3,  8'h00);
    add_req(lcdnf_pkg::ModeSdec, 2'd3, 5'd2,  16'hFFFF, 5'd0,  8'h00);
    add_req(lcdnf_pkg::ModeSdec, 2'd2, 5'd9,  16'h0000, 5'd16, 8'h00);
    add_req(lcdnf_pkg::ModeHex,  2'd1, 5'd4,  16'hABCD, 5'd4,  8'h00);
    add_req(lcdnf_pkg::ModeHex,  2'd2, 5'd1,  16'hFFFF, 5'd16, 8'h00);
    add_req(lcdnf_pkg::ModeHex,  2'd1, 5'd1,  16'h5A5A, 5'd0,  8'h00);
    add_req(lcdnf_pkg::ModeBin,  2'd2, 5'd1,  16'hA5A5, 5'd16, 8'h00);
    add_req(lcdnf_pkg::ModeBin,  2'd0, 5'd7,  16'hFFFF, 5'd31, 8'h00);
    add_req(ModeSpareLo,         2'd1, 5'd5, 16'h1111, 5'd4, 8'h31);
    add_req(ModeSpareLo + 3'd1,  2'd2, 5'd6, 16'h2222, 5'd4, 8'h32);
    add_req(ModeSpareHi,         2'd0, 5'd7, 16'h3333, 5'd4, 8'h33);
    add_req(ModeSpareHi,         2'd3, 5'd8, 16'h4444, 5'd4, 8'h34);
    // random part, mostly in-range fields with the odd out-of-range one
    repeat (RandomReqs) begin
      r.mode = ($urandom_range(0, 9) == 0)
               ? 3'($urandom_range(ModeSpareLo, ModeSpareHi))
               : 3'($urandom_range(lcdnf_pkg::ModeChar, lcdnf_pkg::ModeBin));
      r.line = 2'($urandom);
      r.column = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
      case ($urandom_range(0, 7))
        0:       r.number = 16'h8000;
        1:       r.number = 16'h0000;
        2:       r.number = 16'hFFFF;
        default: r.number = 16'($urandom);
      endcase
      r.digit_count = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
      r.character = 8'($urandom);
      pending_reqs.push_back(r);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || busy || expected_writes.size() != 0);
    repeat (DrainCycles) @(negedge clk);

    if (!failed && expected_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_writes.size() != 0)
        $error("%0d expected writes never arrived", expected_writes.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
